>>> rtl/sdgt_pkg.sv
// Shared types, constants and helpers for the sequence duplicate/gap tracker.
package sdgt_pkg;

  localparam int SEQ_BITS_DEF      = 32;
  localparam int CNT_BITS          = 32;
  localparam int INTERVAL_BITS     = 16;
  localparam logic [CNT_BITS-1:0]      SUMMARY_RESET  = 32'd25;
  localparam logic [INTERVAL_BITS-1:0] INTERVAL_RESET = 16'd25;

  // Configuration register indexes
  typedef enum logic [0:0] {
    CFG_FAULT_TEST       = 1'b0,
    CFG_SUMMARY_INTERVAL = 1'b1
  } cfg_index_t;

  typedef enum logic [1:0] {
    VERDICT_MALFORMED = 2'd0,
    VERDICT_UNIQUE    = 2'd1,
    VERDICT_DUPLICATE = 2'd2
  } verdict_t;

  typedef struct packed {
    verdict_t            verdict;
    logic                send_ack;
    logic                reack;
    logic                ack_suppressed;
    logic [CNT_BITS-1:0] ack_sequence;
    logic [CNT_BITS-1:0] unique_count;
    logic [CNT_BITS-1:0] duplicate_count;
    logic [CNT_BITS-1:0] missing_count;
    logic [CNT_BITS-1:0] malformed_count;
    logic [CNT_BITS-1:0] ack_count;
    logic [CNT_BITS-1:0] suppressed_count;
    logic                summary_due;
  } result_t;

  // Divisible by ten: even, and divisible by five. Since 16 = 1 mod 5, the
  // sum of the hex digits keeps the residue; fold it once more and match.
  function automatic logic div_by_ten(input logic [31:0] v);
    logic [6:0] s;
    logic [4:0] t;
    s = '0;
    for (int i = 0; i < 8; i++) begin
      s = s + 7'(v[4*i +: 4]);
    end
    t = 5'(s[3:0]) + 5'(s[6:4]);
    return !v[0] && (t == 5'd0 || t == 5'd5 || t == 5'd10 || t == 5'd15 || t == 5'd20);
  endfunction

endpackage

>>> rtl/seq_duplicate_gap_tracker.sv
// Top level of the receive-side sequence duplicate/gap tracker.
//
//   channel | signals                               | direction | accepted when
//   --------+---------------------------------------+-----------+--------------------
//   in      | in_valid/in_ready, sequence_req, ...  | into      | in_valid & in_ready
//   out     | out_valid/out_ready, verdict, ...     | out of    | out_valid & out_ready
//   cfg     | cfg_we, cfg_index, cfg_data           | into      | cfg_we
//
// Each item passes an input register, then compare/add logic into the result
// register; one item per cycle is sustained while out_ready stays high.
// The tracker state updates when the item moves into the result register.
// in_ready drops only when both registers hold items and out_ready is low.
// Synchronous reset clears all counters, the summary threshold (25) and the
// configuration (fault test off, interval 25).
module seq_duplicate_gap_tracker
  import sdgt_pkg::*;
#(
  parameter int SEQ_BITS = SEQ_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  // input items
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [31:0]              sequence_req,
  input  logic                     parse_ok,
  // result items
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [1:0]               verdict,
  output logic                     send_ack,
  output logic                     reack,
  output logic                     ack_suppressed,
  output logic [31:0]              ack_sequence,
  output logic [31:0]              unique_count,
  output logic [31:0]              duplicate_count,
  output logic [31:0]              missing_count,
  output logic [31:0]              malformed_count,
  output logic [31:0]              ack_count,
  output logic [31:0]              suppressed_count,
  output logic                     summary_due,
  // configuration writes
  input  logic                     cfg_we,
  input  logic [0:0]               cfg_index,
  input  logic [INTERVAL_BITS-1:0] cfg_data
);

  // Configuration registers
  logic                     fault_test_enable;
  logic [INTERVAL_BITS-1:0] summary_interval;

  // Input stage
  logic                in_full;
  logic [SEQ_BITS-1:0] in_seq;
  logic                in_ok;

  // Result stage
  result_t res;
  result_t res_q;
  logic    advance;

  // Move the held item forward whenever the result register is free or drains.
  assign advance  = in_full && (!out_valid || out_ready);
  assign in_ready = !in_full || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      fault_test_enable <= 1'b0;
      summary_interval  <= INTERVAL_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_FAULT_TEST:       fault_test_enable <= cfg_data[0];
        CFG_SUMMARY_INTERVAL: summary_interval  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Hold the input item; keep only the low SEQ_BITS of the sequence.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_seq <= sequence_req[SEQ_BITS-1:0];
      in_ok  <= parse_ok;
    end
  end

  sdgt_eval #(
    .SEQ_BITS(SEQ_BITS)
  ) u_eval (
    .clk              (clk),
    .rst              (rst),
    .fire             (advance),
    .seq              (in_seq),
    .ok               (in_ok),
    .fault_test_enable(fault_test_enable),
    .summary_interval (summary_interval),
    .res              (res)
  );

  // Result register: load on advance, drop once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_q <= res;
    end
  end

  assign verdict          = res_q.verdict;
  assign send_ack         = res_q.send_ack;
  assign reack            = res_q.reack;
  assign ack_suppressed   = res_q.ack_suppressed;
  assign ack_sequence     = res_q.ack_sequence;
  assign unique_count     = res_q.unique_count;
  assign duplicate_count  = res_q.duplicate_count;
  assign missing_count    = res_q.missing_count;
  assign malformed_count  = res_q.malformed_count;
  assign ack_count        = res_q.ack_count;
  assign suppressed_count = res_q.suppressed_count;
  assign summary_due      = res_q.summary_due;

endmodule

>>> rtl/sdgt_eval.sv
// Tracker state and the per-item classification, counter and summary logic.
module sdgt_eval
  import sdgt_pkg::*;
#(
  parameter int SEQ_BITS = SEQ_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     fire,
  input  logic [SEQ_BITS-1:0]      seq,
  input  logic                     ok,
  input  logic                     fault_test_enable,
  input  logic [INTERVAL_BITS-1:0] summary_interval,
  output result_t                  res
);

  logic                seen_first;
  logic [SEQ_BITS-1:0] last_unique_seq;
  logic [SEQ_BITS-1:0] last_suppressed_seq;
  logic [CNT_BITS-1:0] next_summary_at;
  logic [CNT_BITS-1:0] unique_total;
  logic [CNT_BITS-1:0] duplicate_total;
  logic [CNT_BITS-1:0] missing_total;
  logic [CNT_BITS-1:0] malformed_total;
  logic [CNT_BITS-1:0] ack_total;
  logic [CNT_BITS-1:0] suppressed_total;

  logic                is_dup;
  logic                is_uniq;
  logic                supp;
  logic                ack;
  logic                due;
  logic [SEQ_BITS-1:0] gap;
  logic [CNT_BITS-1:0] unique_next;
  logic [CNT_BITS-1:0] duplicate_next;
  logic [CNT_BITS-1:0] missing_next;
  logic [CNT_BITS-1:0] malformed_next;
  logic [CNT_BITS-1:0] ack_next;
  logic [CNT_BITS-1:0] suppressed_next;

  always_comb begin
    is_dup  = ok && seen_first && (seq <= last_unique_seq);
    is_uniq = ok && !is_dup;
    // All-ones is odd, so the reset value never matches a suppressible sequence.
    supp    = is_uniq && fault_test_enable && div_by_ten(32'(seq)) &&
              (last_suppressed_seq != seq);
    ack     = is_dup || (is_uniq && !supp);
    gap     = seq - last_unique_seq - 1'b1;

    unique_next     = unique_total + CNT_BITS'(is_uniq);
    duplicate_next  = duplicate_total + CNT_BITS'(is_dup);
    malformed_next  = malformed_total + CNT_BITS'(!ok);
    ack_next        = ack_total + CNT_BITS'(ack);
    suppressed_next = suppressed_total + CNT_BITS'(supp);
    missing_next    = (is_uniq && seen_first) ? missing_total + CNT_BITS'(gap)
                                              : missing_total;
    due = ok && (unique_next >= next_summary_at);

    res.verdict          = !ok ? VERDICT_MALFORMED :
                           (is_dup ? VERDICT_DUPLICATE : VERDICT_UNIQUE);
    res.send_ack         = ack;
    res.reack            = is_dup;
    res.ack_suppressed   = supp;
    res.ack_sequence     = ok ? CNT_BITS'(seq) : '0;
    res.unique_count     = unique_next;
    res.duplicate_count  = duplicate_next;
    res.missing_count    = missing_next;
    res.malformed_count  = malformed_next;
    res.ack_count        = ack_next;
    res.suppressed_count = suppressed_next;
    res.summary_due      = due;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seen_first          <= 1'b0;
      last_unique_seq     <= '0;
      last_suppressed_seq <= '1;
      next_summary_at     <= SUMMARY_RESET;
      unique_total        <= '0;
      duplicate_total     <= '0;
      missing_total       <= '0;
      malformed_total     <= '0;
      ack_total           <= '0;
      suppressed_total    <= '0;
    end else if (fire) begin
      unique_total     <= unique_next;
      duplicate_total  <= duplicate_next;
      missing_total    <= missing_next;
      malformed_total  <= malformed_next;
      ack_total        <= ack_next;
      suppressed_total <= suppressed_next;
      if (is_uniq) begin
        seen_first      <= 1'b1;
        last_unique_seq <= seq;
      end
      if (supp) begin
        last_suppressed_seq <= seq;
      end
      if (due) begin
        next_summary_at <= next_summary_at + CNT_BITS'(summary_interval);
      end
    end
  end

endmodule

>>> verif/seq_duplicate_gap_tracker_checker.sv
// Scoreboard for the sequence duplicate/gap tracker: predicts each report and compares it.
`timescale 1ns / 1ps

module seq_duplicate_gap_tracker_checker
  import sdgt_pkg::*;
#(
  parameter int SEQ_BITS = SEQ_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  input  logic                     in_ready,
  input  logic [31:0]              sequence_req,
  input  logic                     parse_ok,
  input  logic                     out_valid,
  input  logic                     out_ready,
  input  logic [1:0]               verdict,
  input  logic                     send_ack,
  input  logic                     reack,
  input  logic                     ack_suppressed,
  input  logic [31:0]              ack_sequence,
  input  logic [31:0]              unique_count,
  input  logic [31:0]              duplicate_count,
  input  logic [31:0]              missing_count,
  input  logic [31:0]              malformed_count,
  input  logic [31:0]              ack_count,
  input  logic [31:0]              suppressed_count,
  input  logic                     summary_due,
  input  logic                     cfg_we,
  input  logic [0:0]               cfg_index,
  input  logic [INTERVAL_BITS-1:0] cfg_data,
  output int                       fail_count,
  output int                       pending,
  output int                       n_unique,
  output int                       n_duplicate,
  output int                       n_malformed,
  output int                       n_withheld,
  output int                       n_summary
);

  localparam logic [31:0] SEQ_MASK =
    (SEQ_BITS >= 32) ? 32'hFFFF_FFFF : ((32'd1 << SEQ_BITS) - 32'd1);
  localparam logic [31:0] ACK_TEST_PERIOD = 32'd10;

  // shadow configuration
  logic                     withhold_mode;
  logic [INTERVAL_BITS-1:0] report_interval;

  // shadow tracker state
  logic                got_first;
  logic [31:0]         last_unique;
  logic [31:0]         last_withheld;
  logic [31:0]         summary_at;
  logic [CNT_BITS-1:0] unique_total;
  logic [CNT_BITS-1:0] dup_total;
  logic [CNT_BITS-1:0] missing_total;
  logic [CNT_BITS-1:0] malformed_total;
  logic [CNT_BITS-1:0] ack_total;
  logic [CNT_BITS-1:0] withheld_total;

  result_t reports_due[$];
  int      errors;

  assign fail_count = errors;

  initial begin
    errors      = 0;
    pending     = 0;
    n_unique    = 0;
    n_duplicate = 0;
    n_malformed = 0;
    n_withheld  = 0;
    n_summary   = 0;
  end

  function automatic logic summary_reached();
    if (unique_total >= summary_at) begin
      summary_at = summary_at + 32'(report_interval);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic result_t track_packet(input logic [31:0] seq_in, input logic ok);
    result_t     r;
    logic [31:0] seq;
    seq = seq_in & SEQ_MASK;
    r   = '0;
    if (!ok) begin
      malformed_total = malformed_total + 1'b1;
      r.verdict = VERDICT_MALFORMED;
    end else if (got_first && seq <= last_unique) begin
      r.verdict      = VERDICT_DUPLICATE;
      r.send_ack     = 1'b1;
      r.reack        = 1'b1;
      r.ack_sequence = seq;
      dup_total = dup_total + 1'b1;
      ack_total = ack_total + 1'b1;
      r.summary_due = summary_reached();
    end else begin
      r.verdict      = VERDICT_UNIQUE;
      r.ack_sequence = seq;
      if (got_first) missing_total = missing_total + (seq - last_unique - 32'd1);
      unique_total = unique_total + 1'b1;
      last_unique  = seq;
      got_first    = 1'b1;
      if (withhold_mode && (seq % ACK_TEST_PERIOD) == 32'd0 && last_withheld != seq) begin
        last_withheld    = seq;
        r.ack_suppressed = 1'b1;
        withheld_total   = withheld_total + 1'b1;
      end else begin
        r.send_ack = 1'b1;
        ack_total  = ack_total + 1'b1;
      end
      r.summary_due = summary_reached();
    end
    r.unique_count     = unique_total;
    r.duplicate_count  = dup_total;
    r.missing_count    = missing_total;
    r.malformed_count  = malformed_total;
    r.ack_count        = ack_total;
    r.suppressed_count = withheld_total;
    return r;
  endfunction

  task automatic compare_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin : watch
    result_t want;
    if (rst) begin
      withhold_mode   = 1'b0;
      report_interval = INTERVAL_RESET;
      got_first       = 1'b0;
      last_unique     = '0;
      last_withheld   = '1;
      summary_at      = SUMMARY_RESET;
      unique_total    = '0;
      dup_total       = '0;
      missing_total   = '0;
      malformed_total = '0;
      ack_total       = '0;
      withheld_total  = '0;
      reports_due.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_FAULT_TEST) withhold_mode = cfg_data[0];
        else if (cfg_index == CFG_SUMMARY_INTERVAL) report_interval = cfg_data;
      end
      // check the outgoing report before queueing a new one: the block cannot
      // answer an item in the cycle it takes it
      if (out_valid && out_ready) begin
        if (reports_due.size() == 0) begin
          $display("%0t: report with no packet waiting, verdict %0h ack_sequence %0h",
                   $time, verdict, ack_sequence);
          errors++;
        end else begin
          want = reports_due.pop_front();
          compare_field("verdict", 32'(want.verdict), 32'(verdict));
          compare_field("send_ack", 32'(want.send_ack), 32'(send_ack));
          compare_field("reack", 32'(want.reack), 32'(reack));
          compare_field("ack_suppressed", 32'(want.ack_suppressed), 32'(ack_suppressed));
          compare_field("ack_sequence", want.ack_sequence, ack_sequence);
          compare_field("unique_count", want.unique_count, unique_count);
          compare_field("duplicate_count", want.duplicate_count, duplicate_count);
          compare_field("missing_count", want.missing_count, missing_count);
          compare_field("malformed_count", want.malformed_count, malformed_count);
          compare_field("ack_count", want.ack_count, ack_count);
          compare_field("suppressed_count", want.suppressed_count, suppressed_count);
          compare_field("summary_due", 32'(want.summary_due), 32'(summary_due));
        end
      end
      if (in_valid && in_ready) begin
        want = track_packet(sequence_req, parse_ok);
        reports_due.push_back(want);
        case (want.verdict)
          VERDICT_UNIQUE:    n_unique++;
          VERDICT_DUPLICATE: n_duplicate++;
          default:           n_malformed++;
        endcase
        if (want.ack_suppressed) n_withheld++;
        if (want.summary_due) n_summary++;
      end
    end
    pending <= reports_due.size();
  end

endmodule

>>> verif/seq_duplicate_gap_tracker_test.sv
// Testbench top for the sequence duplicate/gap tracker: stimulus, stalls and verdict.
`timescale 1ns / 1ps

module seq_duplicate_gap_tracker_test;
  import sdgt_pkg::*;

  localparam int          SEQ_W           = SEQ_BITS_DEF;
  localparam int          PHASES          = 6;
  localparam int          PHASE_ITEMS     = 305;
  localparam int          LONG_HOLD       = 200;
  localparam int          IDLE_LIMIT      = 3000;
  localparam int          TAIL_CYCLES     = 10;
  localparam logic [31:0] ACK_TEST_PERIOD = 32'd10;
  // keep room at the top of the sequence space for the closing packets
  localparam logic [31:0] HEAD_CEILING    = 32'hF800_0000;
  localparam logic [31:0] PHASE_JUMP      = 32'h2600_0000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  // input channel
  logic        in_valid     = 1'b0;
  logic        in_ready;
  logic [31:0] sequence_req = '0;
  logic        parse_ok     = 1'b0;

  // result channel
  logic        out_valid;
  logic        out_ready    = 1'b0;
  logic [1:0]  verdict;
  logic        send_ack;
  logic        reack;
  logic        ack_suppressed;
  logic [31:0] ack_sequence;
  logic [31:0] unique_count;
  logic [31:0] duplicate_count;
  logic [31:0] missing_count;
  logic [31:0] malformed_count;
  logic [31:0] ack_count;
  logic [31:0] suppressed_count;
  logic        summary_due;

  // configuration port
  logic                     cfg_we    = 1'b0;
  logic [0:0]               cfg_index = CFG_FAULT_TEST;
  logic [INTERVAL_BITS-1:0] cfg_data  = '0;

  // scoreboard outputs
  int fail_count;
  int pending;
  int n_unique;
  int n_duplicate;
  int n_malformed;
  int n_withheld;
  int n_summary;

  // set by the stimulus, cleared by the sink once it starts the long hold-off
  bit hold_request = 1'b0;

  // highest unique sequence sent so far
  logic [31:0] head_seq;
  int          settings_used;
  int          idle_cycles;

  seq_duplicate_gap_tracker #(.SEQ_BITS(SEQ_W)) i_dut (.*);

  seq_duplicate_gap_tracker_checker #(.SEQ_BITS(SEQ_W)) i_checker (.*);

  initial begin
    forever #10 clk = ~clk;
  end

  // Mostly back-to-back, some short gaps, a few long ones.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  // Offer one packet and hold it until the block takes it.
  task automatic send_packet(input logic [31:0] seq, input logic ok);
    in_valid     <= 1'b1;
    sequence_req <= seq;
    parse_ok     <= ok;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic pause_sender(input int cycles);
    if (cycles > 0) begin
      in_valid <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  // Stop offering and wait until every report is back; leave a few cycles so
  // the pipeline is empty before the next register write.
  task automatic drain_reports();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_index_t idx, input logic [INTERVAL_BITS-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // One random packet: mostly fresh sequences, then re-sent ones and noise.
  task automatic send_random_item();
    int          kind;
    int          pick;
    logic [31:0] seq;
    kind = $urandom_range(99);
    if (kind < 60) begin
      pick = $urandom_range(99);
      if (head_seq >= HEAD_CEILING || pick < 65) seq = head_seq + 32'd1;
      else if (pick < 80) seq = head_seq + (ACK_TEST_PERIOD - (head_seq % ACK_TEST_PERIOD));
      else if (pick < 92) seq = head_seq + 32'($urandom_range(12, 2));
      else if (pick < 97) seq = head_seq + 32'($urandom_range(1000, 13));
      else seq = head_seq + 32'($urandom_range(32'h0010_0000, 1001));
      head_seq = seq;
      send_packet(seq, 1'b1);
    end else if (kind < 85) begin
      // re-send: either the last unique one or anything below it
      if ($urandom_range(2) == 0) seq = head_seq;
      else seq = $urandom_range(head_seq, 0);
      send_packet(seq, 1'b1);
    end else begin
      send_packet($urandom, 1'b0);
    end
  endtask

  // Result side: random stalls, steady stretches and one long hold-off on request.
  initial begin : sink
    int n;
    int steady_left;
    steady_left = 0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
      if (steady_left > 0) begin
        steady_left--;
        n = 0;
      end else if ($urandom_range(99) < 3) begin
        steady_left = $urandom_range(100, 40);
        n = 0;
      end else begin
        n = pick_gap();
      end
      if (n == 0) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b0;
        repeat (n) @(posedge clk);
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog: end the run if nothing moves on either channel for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no item moved for %0d cycles, %0d reports outstanding",
               $time, IDLE_LIMIT, pending);
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    logic [INTERVAL_BITS-1:0] mode_data [PHASES];
    logic [INTERVAL_BITS-1:0] interval_data [PHASES];
    bit                       steady;

    // fault test on, off and on again through data words with junk in the upper bits;
    // intervals cover 1, 65535 and the zero interval that never advances
    mode_data     = '{16'h0001, 16'hFFFE, 16'h8003, 16'($urandom), 16'h0001, 16'h0000};
    interval_data = '{16'd1, 16'hFFFF, 16'd0, 16'($urandom_range(40, 2)), 16'd7, 16'd25};

    idle_cycles   = 0;
    settings_used = 1;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed: malformed at both ends of the range, first packet at zero,
    // duplicates below and equal to the last unique one, a gap, default config.
    send_packet(32'hFFFF_FFFF, 1'b0);
    send_packet(32'h0000_0000, 1'b0);
    send_packet(32'd0, 1'b1);
    send_packet(32'd0, 1'b1);
    send_packet(32'd1, 1'b1);
    send_packet(32'd10, 1'b1);
    send_packet(32'd7, 1'b1);
    send_packet(32'd10, 1'b1);
    drain_reports();

    // Fault test on: multiples of ten get no ACK, but their re-sends are re-ACKed.
    write_reg(CFG_FAULT_TEST, 16'h0001);
    write_reg(CFG_SUMMARY_INTERVAL, 16'd3);
    settings_used++;
    send_packet(32'd20, 1'b1);
    send_packet(32'd20, 1'b1);
    send_packet(32'd21, 1'b1);
    send_packet(32'd30, 1'b1);
    send_packet(32'h5555_5555, 1'b0);
    send_packet(32'hAAAA_AAAA, 1'b0);
    send_packet(32'd35, 1'b1);
    send_packet(32'd40, 1'b1);
    send_packet(32'd41, 1'b1);
    head_seq = 32'd41;

    for (int p = 0; p < PHASES; p++) begin
      drain_reports();
      write_reg(CFG_FAULT_TEST, mode_data[p]);
      write_reg(CFG_SUMMARY_INTERVAL, interval_data[p]);
      settings_used++;
      // push the sequence space upward so later phases exercise the high bits
      head_seq = head_seq + PHASE_JUMP;
      send_packet(head_seq, 1'b1);
      if (p == 1) hold_request = 1'b1;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // during the hold-off keep offering back to back so the block backs up
        steady = ((i % 100) < 25) || (p == 1 && i < 150);
        send_random_item();
        if (!steady) pause_sender(pick_gap());
      end
    end

    // Close at the top of the range: the largest unique sequence, then its
    // re-send, a re-send of zero and a last malformed packet.
    send_packet(32'hFFFF_FFFF, 1'b1);
    send_packet(32'hFFFF_FFFF, 1'b1);
    send_packet(32'd0, 1'b1);
    send_packet(32'd0, 1'b0);

    drain_reports();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Covered %0d unique, %0d duplicate and %0d malformed packets, %0d ACKs withheld,",
             n_unique, n_duplicate, n_malformed, n_withheld);
    $display("%0d summary pulses, across %0d register settings.", n_summary, settings_used);
    if (fail_count == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
